/* design/tpa_pkg.sv */
// Shared widths, stage counts and the square root step type for the
// triangle perimeter/area pipeline. No dependencies.
package tpa_pkg;

  localparam int COORD_W    = 16;
  localparam int DIFF_W     = COORD_W;           // |p - q| fits unsigned
  localparam int SQ_W       = 2 * COORD_W + 1;   // dx^2 + dy^2
  localparam int SIDE_STEPS = (SQ_W + 1) / 2;
  localparam int SIDE_W     = SIDE_STEPS;        // floor root of a side
  localparam int PER_W      = 19;                // perimeter field width
  localparam int AREA_W     = 31;                // area field width
  // Internal perimeter sum: three sides never wrap, never narrower than the field.
  localparam int PSUM_W     = (SIDE_W + 2 > PER_W) ? SIDE_W + 2 : PER_W;
  localparam int F_W        = 2 * PSUM_W;        // one two-factor product
  localparam int HALF_W     = PSUM_W;            // split of f2 for partials
  localparam int PP_W       = F_W + HALF_W;      // one partial product
  localparam int RAD_W      = 2 * F_W;           // 16 * area^2
  localparam int AREA_STEPS = RAD_W / 2;
  localparam int ROOT_W     = AREA_STEPS;
  localparam int REM_W      = ROOT_W + 3;
  localparam int SIDE_PAD   = RAD_W - 2 * SIDE_STEPS;

  localparam logic [PER_W-1:0]  PERIM_MAX = {PER_W{1'b1}};
  localparam logic [AREA_W-1:0] AREA_MAX  = {AREA_W{1'b1}};

  // One digit step of the restoring square root: radicand left to consume,
  // partial remainder and partial root.
  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } tpa_sq_t;

endpackage

/* design/tpa_sqrt_cell.sv */
// One registered digit step of a restoring integer square root.
// Depends on tpa_pkg.
module tpa_sqrt_cell import tpa_pkg::*; (
  input  logic    clk,
  input  logic    en,
  input  tpa_sq_t d_i,
  output tpa_sq_t q_o
);

  tpa_sq_t           q_r, q_nxt;
  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;

  always_comb begin
    rem_sh = {d_i.rem[REM_W-3:0], d_i.rad[RAD_W-1 -: 2]};
    trial  = {1'b0, d_i.root, 2'b01};
    q_nxt.rad = {d_i.rad[RAD_W-3:0], 2'b00};
    if (rem_sh >= trial) begin
      q_nxt.rem  = rem_sh - trial;
      q_nxt.root = {d_i.root[ROOT_W-2:0], 1'b1};
    end else begin
      q_nxt.rem  = rem_sh;
      q_nxt.root = {d_i.root[ROOT_W-2:0], 1'b0};
    end
  end

  // Advance only with the pipeline; no reset on payload.
  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
    end
  end

  assign q_o = q_r;

endmodule

/* design/tpa_side_chain.sv */
// Three lanes of square root cells, one lane per triangle side.
// Depends on tpa_pkg and tpa_sqrt_cell.
module tpa_side_chain import tpa_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [SQ_W-1:0]   sq_i   [3],
  output logic [SIDE_W-1:0] side_o [3]
);

  tpa_sq_t stg [3][SIDE_STEPS+1];

  for (genvar l = 0; l < 3; l++) begin : g_lane
    assign stg[l][0].rad  = {1'b0, sq_i[l], {SIDE_PAD{1'b0}}};
    assign stg[l][0].rem  = '0;
    assign stg[l][0].root = '0;
    for (genvar s = 0; s < SIDE_STEPS; s++) begin : g_cell
      tpa_sqrt_cell u_cell (
        .clk (clk),
        .en  (en),
        .d_i (stg[l][s]),
        .q_o (stg[l][s+1])
      );
    end
    assign side_o[l] = stg[l][SIDE_STEPS].root[SIDE_W-1:0];
  end

endmodule

/* design/tpa_area_chain.sv */
// Row of square root cells for the Heron product.
// Depends on tpa_pkg and tpa_sqrt_cell.
module tpa_area_chain import tpa_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [RAD_W-1:0]  rad_i,
  output logic [ROOT_W-1:0] root_o
);

  tpa_sq_t stg [AREA_STEPS+1];

  assign stg[0].rad  = rad_i;
  assign stg[0].rem  = '0;
  assign stg[0].root = '0;

  for (genvar s = 0; s < AREA_STEPS; s++) begin : g_cell
    tpa_sqrt_cell u_cell (
      .clk (clk),
      .en  (en),
      .d_i (stg[s]),
      .q_o (stg[s+1])
    );
  end

  assign root_o = stg[AREA_STEPS].root;

endmodule

/* design/triangle_perimeter_area_core.sv */
// Triangle perimeter and Heron area; uses tpa_pkg, tpa_side_chain, tpa_area_chain.
// Stages from input beat to result: 2 prep, 17 side root cells,
// 5 product stages, 38 area root cells, 1 output register.
// Throughput: one beat per cycle; the whole pipeline stalls only while a
// result sits in the output register and out_ready is low.
// Reset (rst_n low, synchronous) clears stage valid bits and out_valid.
module triangle_perimeter_area_core import tpa_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [COORD_W-1:0] in_ax,
  input  logic signed [COORD_W-1:0] in_ay,
  input  logic signed [COORD_W-1:0] in_bx,
  input  logic signed [COORD_W-1:0] in_by_coord,
  input  logic signed [COORD_W-1:0] in_cx,
  input  logic signed [COORD_W-1:0] in_cy,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [PER_W-1:0]          out_perimeter,
  output logic [AREA_W-1:0]         out_area
);

  // Valid bits: diff, square, side cells, sum, factor, product, partial,
  // radicand, area cells.
  localparam int PRE_LAT  = 2 + SIDE_STEPS;
  localparam int VLD_LAT  = PRE_LAT + 5 + AREA_STEPS;
  localparam int PER_LAT  = 4 + AREA_STEPS;   // perimeter taps after its sum

  logic adv;

  // Whole pipeline moves when the output register can take a beat.
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  logic [VLD_LAT-1:0] vld_r, vld_nxt;

  assign vld_nxt = {vld_r[VLD_LAT-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= vld_nxt;
    end
  end

  // Stage 1: absolute coordinate differences for each side.
  // Side a = |BC|, b = |CA|, c = |AB|.
  function automatic logic [DIFF_W-1:0] abs_diff(logic signed [COORD_W-1:0] p,
                                                 logic signed [COORD_W-1:0] q);
    logic signed [COORD_W:0] d;
    d = {p[COORD_W-1], p} - {q[COORD_W-1], q};
    return d[COORD_W] ? DIFF_W'(-d) : d[DIFF_W-1:0];
  endfunction

  logic [DIFF_W-1:0] dx_r [3];
  logic [DIFF_W-1:0] dy_r [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      dx_r[0] <= abs_diff(in_bx, in_cx);
      dy_r[0] <= abs_diff(in_by_coord, in_cy);
      dx_r[1] <= abs_diff(in_cx, in_ax);
      dy_r[1] <= abs_diff(in_cy, in_ay);
      dx_r[2] <= abs_diff(in_ax, in_bx);
      dy_r[2] <= abs_diff(in_ay, in_by_coord);
    end
  end

  // Stage 2: squared side lengths.
  logic [SQ_W-1:0] sq_r [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        sq_r[i] <= SQ_W'(dx_r[i]) * SQ_W'(dx_r[i]) + SQ_W'(dy_r[i]) * SQ_W'(dy_r[i]);
      end
    end
  end

  logic [SIDE_W-1:0] side [3];

  tpa_side_chain u_side (
    .clk    (clk),
    .en     (adv),
    .sq_i   (sq_r),
    .side_o (side)
  );

  // Perimeter and the clamped factors P - 2s.
  logic [PSUM_W-1:0] per_r;
  logic [SIDE_W-1:0] side_r [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      per_r <= PSUM_W'(side[0]) + PSUM_W'(side[1]) + PSUM_W'(side[2]);
      side_r <= side;
    end
  end

  function automatic logic [PSUM_W-1:0] clamp_fac(logic [PSUM_W-1:0] p,
                                                  logic [SIDE_W-1:0] s);
    logic [PSUM_W-1:0] twice;
    twice = PSUM_W'({s, 1'b0});
    return (twice >= p) ? '0 : p - twice;
  endfunction

  logic [PSUM_W-1:0] fac_r [3];
  logic [PSUM_W-1:0] per_pipe_r [PER_LAT];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        fac_r[i] <= clamp_fac(per_r, side_r[i]);
      end
      per_pipe_r[0] <= per_r;
      for (int i = 1; i < PER_LAT; i++) begin
        per_pipe_r[i] <= per_pipe_r[i-1];
      end
    end
  end

  // Two-factor products, then split the wide product into two partials.
  logic [F_W-1:0]  f1_r, f2_r;
  logic [PP_W-1:0] pp_lo_r, pp_hi_r;
  logic [RAD_W-1:0] rad_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      f1_r    <= F_W'(per_pipe_r[0]) * F_W'(fac_r[0]);
      f2_r    <= F_W'(fac_r[1]) * F_W'(fac_r[2]);
      pp_lo_r <= PP_W'(f1_r) * PP_W'(f2_r[HALF_W-1:0]);
      pp_hi_r <= PP_W'(f1_r) * PP_W'(f2_r[F_W-1:HALF_W]);
      rad_r   <= RAD_W'(pp_lo_r) + (RAD_W'(pp_hi_r) << HALF_W);
    end
  end

  logic [ROOT_W-1:0] root;

  tpa_area_chain u_area (
    .clk    (clk),
    .en     (adv),
    .rad_i  (rad_r),
    .root_o (root)
  );

  // Output register: divide the root by four and saturate both fields.
  logic                   out_valid_r;
  logic [PER_W-1:0]       perim_r;
  logic [AREA_W-1:0]      area_r;
  logic [ROOT_W-3:0]      area_q;
  logic [PSUM_W-1:0]      per_last;

  assign area_q   = root[ROOT_W-1:2];
  assign per_last = per_pipe_r[PER_LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vld_r[VLD_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      perim_r <= (per_last > PSUM_W'(PERIM_MAX)) ? PERIM_MAX : per_last[PER_W-1:0];
      area_r  <= (area_q > (ROOT_W-2)'(AREA_MAX)) ? AREA_MAX : area_q[AREA_W-1:0];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_perimeter = perim_r;
  assign out_area      = area_r;

  // A waiting result must freeze the pipeline.
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input taken while result stalled");

  // A result with zero perimeter is a point triangle with zero area.
  a_zero_perim_area: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_perimeter == '0) |-> (out_area == '0))
    else $error("nonzero area with zero perimeter");

  // Reset leaves no result pending.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule
